[rtl/bwt_pkg.sv]
package bwt_pkg;

    // field widths
    localparam int CMD_W      = 1;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 3;
    localparam int STATE_W    = 3;
    localparam int PCT_W      = 7;
    localparam int SEC_W      = 24;
    localparam int LVL_W      = 3;
    localparam int ALARM_W    = 2;
    localparam int SEV_W      = 2;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SLOT_COUNT = 2 ** SLOT_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b1;

    // device kinds
    localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BATTERY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPS      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOUSE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_KEYBOARD = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PDA      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PHONE    = 3'd6;

    // charge states
    localparam logic [STATE_W-1:0] CS_DISCHARGING = 3'd2;
    localparam logic [STATE_W-1:0] CS_FULL        = 3'd3;

    // warning levels
    localparam logic [LVL_W-1:0] LVL_NONE        = 3'd0;
    localparam logic [LVL_W-1:0] LVL_DISCHARGING = 3'd1;
    localparam logic [LVL_W-1:0] LVL_LOW         = 3'd2;
    localparam logic [LVL_W-1:0] LVL_CRITICAL    = 3'd3;
    localparam logic [LVL_W-1:0] LVL_ACTION      = 3'd4;

    // alarm events
    localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
    localparam logic [ALARM_W-1:0] ALARM_LOW      = 2'd1;
    localparam logic [ALARM_W-1:0] ALARM_CRITICAL = 2'd2;
    localparam logic [ALARM_W-1:0] ALARM_ACTION   = 2'd3;

    // state events
    localparam logic [SEV_W-1:0] SEV_NONE        = 2'd0;
    localparam logic [SEV_W-1:0] SEV_DISCHARGING = 2'd1;
    localparam logic [SEV_W-1:0] SEV_FULL        = 2'd2;

    // notify mask bits
    localparam int NOTIFY_DISCHARGE = 0;
    localparam int NOTIFY_FULL      = 1;
    localparam int NOTIFY_CAPACITY  = 2;

    // fixed limits
    localparam logic [PCT_W-1:0] PERIPH_LOW_LIMIT  = 7'd26;
    localparam logic [PCT_W-1:0] PERIPH_CRIT_LIMIT = 7'd13;
    localparam logic [PCT_W-1:0] CAPACITY_LIMIT    = 7'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERCENT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_PERCENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_PERCENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SECONDS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_SECONDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_SECONDS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_TIME_POLICY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_MASK      = 3'd7;

    // register reset values
    localparam logic [PCT_W-1:0]  RST_LOW_PERCENT      = 7'd10;
    localparam logic [PCT_W-1:0]  RST_CRITICAL_PERCENT = 7'd3;
    localparam logic [PCT_W-1:0]  RST_ACTION_PERCENT   = 7'd2;
    localparam logic [SEC_W-1:0]  RST_LOW_SECONDS      = 24'd1200;
    localparam logic [SEC_W-1:0]  RST_CRITICAL_SECONDS = 24'd300;
    localparam logic [SEC_W-1:0]  RST_ACTION_SECONDS   = 24'd120;
    localparam logic              RST_USE_TIME_POLICY  = 1'b1;
    localparam logic [MASK_W-1:0] RST_NOTIFY_MASK      = 3'd7;

    typedef struct packed {
        logic [PCT_W-1:0]  low_percent;
        logic [PCT_W-1:0]  critical_percent;
        logic [PCT_W-1:0]  action_percent;
        logic [SEC_W-1:0]  low_seconds;
        logic [SEC_W-1:0]  critical_seconds;
        logic [SEC_W-1:0]  action_seconds;
        logic              use_time_policy;
        logic [MASK_W-1:0] notify_mask;
    } cfg_t;

    // classified report passed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  slot;
        logic               in_table;
        logic [LVL_W-1:0]   level;
        logic [STATE_W-1:0] state;
        logic               cap_low;
        logic [PCT_W-1:0]   capacity;
    } item_t;

    typedef struct packed {
        logic [LVL_W-1:0]   warning_level;
        logic [ALARM_W-1:0] alarm_event;
        logic [SEV_W-1:0]   state_event;
        logic               capacity_alert;
        logic [PCT_W-1:0]   capacity_out;
    } result_t;

endpackage

[rtl/bwt_ram.sv]
module bwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bwt_fifo.sv]
module bwt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/bwt_front.sv]
module bwt_front #(
    parameter int MAX_DEVICES = 16
) (
    input  logic [bwt_pkg::CMD_W-1:0]   command,
    input  logic [bwt_pkg::SLOT_W-1:0]  device_slot,
    input  logic [bwt_pkg::KIND_W-1:0]  device_kind,
    input  logic [bwt_pkg::STATE_W-1:0] charge_state,
    input  logic [bwt_pkg::PCT_W-1:0]   charge_percent,
    input  logic [bwt_pkg::SEC_W-1:0]   seconds_to_empty,
    input  logic [bwt_pkg::PCT_W-1:0]   capacity_percent,
    input  bwt_pkg::cfg_t               cfg,
    output bwt_pkg::item_t              item
);

    localparam logic [8:0] TABLE_LIMIT = 9'(MAX_DEVICES);

    logic [bwt_pkg::LVL_W-1:0] pct_level;
    logic [bwt_pkg::LVL_W-1:0] time_level;
    logic [bwt_pkg::LVL_W-1:0] periph_level;
    logic [bwt_pkg::LVL_W-1:0] kind_level;
    logic [bwt_pkg::LVL_W-1:0] level;

    // percent thresholds, zero percent means no reading
    always_comb
    begin
        if (charge_percent == '0)
            pct_level = bwt_pkg::LVL_NONE;
        else if (charge_percent <= cfg.action_percent)
            pct_level = bwt_pkg::LVL_ACTION;
        else if (charge_percent <= cfg.critical_percent)
            pct_level = bwt_pkg::LVL_CRITICAL;
        else if (charge_percent <= cfg.low_percent)
            pct_level = bwt_pkg::LVL_LOW;
        else
            pct_level = bwt_pkg::LVL_NONE;
    end

    // time thresholds, zero time falls back to percent
    always_comb
    begin
        if (seconds_to_empty == '0)
            time_level = pct_level;
        else if (seconds_to_empty <= cfg.action_seconds)
            time_level = bwt_pkg::LVL_ACTION;
        else if (seconds_to_empty <= cfg.critical_seconds)
            time_level = bwt_pkg::LVL_CRITICAL;
        else if (seconds_to_empty <= cfg.low_seconds)
            time_level = bwt_pkg::LVL_LOW;
        else
            time_level = bwt_pkg::LVL_NONE;
    end

    always_comb
    begin
        if (charge_percent < bwt_pkg::PERIPH_CRIT_LIMIT)
            periph_level = bwt_pkg::LVL_CRITICAL;
        else if (charge_percent < bwt_pkg::PERIPH_LOW_LIMIT)
            periph_level = bwt_pkg::LVL_LOW;
        else
            periph_level = bwt_pkg::LVL_NONE;
    end

    always_comb
    begin
        case (device_kind)
            bwt_pkg::KIND_MOUSE, bwt_pkg::KIND_KEYBOARD:
                kind_level = periph_level;
            bwt_pkg::KIND_UPS, bwt_pkg::KIND_PDA, bwt_pkg::KIND_PHONE:
                kind_level = pct_level;
            bwt_pkg::KIND_BATTERY:
                kind_level = cfg.use_time_policy ? time_level : pct_level;
            default:
                kind_level = bwt_pkg::LVL_NONE;
        endcase
    end

    assign level = ((kind_level == bwt_pkg::LVL_NONE) &&
                    (charge_state == bwt_pkg::CS_DISCHARGING))
                   ? bwt_pkg::LVL_DISCHARGING : kind_level;

    always_comb
    begin
        item.command  = command;
        item.slot     = device_slot;
        item.in_table = ({5'd0, device_slot} < TABLE_LIMIT);
        item.level    = level;
        item.state    = charge_state;
        item.cap_low  = (device_kind == bwt_pkg::KIND_BATTERY) &&
                        (capacity_percent <= bwt_pkg::CAPACITY_LIMIT);
        item.capacity = capacity_percent;
    end

endmodule

[rtl/bwt_back.sv]
module bwt_back #(
    parameter int MAX_DEVICES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bwt_pkg::cfg_t   cfg,
    input  bwt_pkg::item_t  item,
    input  logic            item_empty,
    output logic            item_pop,
    output bwt_pkg::result_t result,
    output logic            result_push,
    input  logic            result_full
);

    localparam int TABLE_DEPTH = (MAX_DEVICES < bwt_pkg::SLOT_COUNT)
                                 ? MAX_DEVICES : bwt_pkg::SLOT_COUNT;
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W     = bwt_pkg::LVL_W + bwt_pkg::STATE_W;

    localparam logic S_FETCH = 1'b0;
    localparam logic S_EXEC  = 1'b1;

    logic                        state_reg, state_next;
    logic                        rd_en;
    logic                        wr_en;
    logic [AW-1:0]               addr;
    logic [ENTRY_W-1:0]          rd_data;
    logic [bwt_pkg::LVL_W-1:0]   old_level;
    logic [bwt_pkg::STATE_W-1:0] old_state;
    logic                        is_update;
    logic [bwt_pkg::ALARM_W-1:0] alarm;
    logic [bwt_pkg::SEV_W-1:0]   sev;

    assign addr = item.slot[AW-1:0];
    assign {old_level, old_state} = rd_data;

    bwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data ({item.level, item.state}),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // fetch the slot entry, then finish the item once the table word is back and the result queue has room
    always_comb
    begin
        state_next  = state_reg;
        rd_en       = 1'b0;
        item_pop    = 1'b0;
        result_push = 1'b0;
        case (state_reg)
            S_FETCH:
            begin
                if (!item_empty)
                begin
                    rd_en      = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!result_full)
                begin
                    item_pop    = 1'b1;
                    result_push = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            default:
                state_next = S_FETCH;
        endcase
    end

    assign wr_en     = result_push && item.in_table;
    assign is_update = item.in_table && (item.command == bwt_pkg::CMD_UPDATE);

    always_comb
    begin
        alarm = bwt_pkg::ALARM_NONE;
        if (is_update && (item.level != old_level))
        begin
            case (item.level)
                bwt_pkg::LVL_LOW:      alarm = bwt_pkg::ALARM_LOW;
                bwt_pkg::LVL_CRITICAL: alarm = bwt_pkg::ALARM_CRITICAL;
                bwt_pkg::LVL_ACTION:   alarm = bwt_pkg::ALARM_ACTION;
                default:               alarm = bwt_pkg::ALARM_NONE;
            endcase
        end
    end

    always_comb
    begin
        sev = bwt_pkg::SEV_NONE;
        if (is_update && (item.state != old_state))
        begin
            if ((item.state == bwt_pkg::CS_DISCHARGING) &&
                cfg.notify_mask[bwt_pkg::NOTIFY_DISCHARGE])
                sev = bwt_pkg::SEV_DISCHARGING;
            else if ((item.state == bwt_pkg::CS_FULL) &&
                     cfg.notify_mask[bwt_pkg::NOTIFY_FULL])
                sev = bwt_pkg::SEV_FULL;
        end
    end

    always_comb
    begin
        result.warning_level  = item.level;
        result.alarm_event    = alarm;
        result.state_event    = sev;
        result.capacity_alert = item.in_table && (item.command == bwt_pkg::CMD_ADD) &&
                                item.cap_low && cfg.notify_mask[bwt_pkg::NOTIFY_CAPACITY];
        result.capacity_out   = result.capacity_alert ? item.capacity : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_FETCH;
        else
            state_reg <= state_next;
    end

    // an item leaves only from the execute step, after its table read
    a_pop_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (state_reg == S_EXEC))
        else $error("item finished without a table read");

    // a read is always followed by the execute step
    a_fetch_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == S_EXEC) && !rd_en)
        else $error("table read not followed by execute");

    // events only come from an update, capacity flag only from an add
    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_push && ((result.alarm_event != bwt_pkg::ALARM_NONE) ||
                        (result.state_event != bwt_pkg::SEV_NONE))
        |-> is_update && !result.capacity_alert)
        else $error("event on a non-update beat");

endmodule

[rtl/battery_warning_tracker_core.sv]
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------------
// report   | in        | push / full          | command, device_slot, device_kind,
//          |           |                      | charge_state, charge_percent,
//          |           |                      | seconds_to_empty, capacity_percent
// result   | out       | pop / empty          | warning_level, alarm_event, state_event,
//          |           |                      | capacity_alert, capacity_out
// config   | in        | cfg_write            | cfg_index, cfg_data
//
// the back end handles each report as a registered read of the slot table, then
// forming the result and writing the slot back; it takes no new report before the last
// is pushed to the result queue, and it waits while that queue is full
// reset loads the register defaults and empties both queues; the slot table
// has no clear and holds garbage until a slot is added
// 2-deep queues sit before and after the back end; pop stalls block push once both fill
module battery_warning_tracker_core #(
    parameter int MAX_DEVICES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // report queue side
    input  logic                              push,
    output logic                              full,
    input  logic [bwt_pkg::CMD_W-1:0]         command,
    input  logic [bwt_pkg::SLOT_W-1:0]        device_slot,
    input  logic [bwt_pkg::KIND_W-1:0]        device_kind,
    input  logic [bwt_pkg::STATE_W-1:0]       charge_state,
    input  logic [bwt_pkg::PCT_W-1:0]         charge_percent,
    input  logic [bwt_pkg::SEC_W-1:0]         seconds_to_empty,
    input  logic [bwt_pkg::PCT_W-1:0]         capacity_percent,

    // result queue side
    output logic                              empty,
    input  logic                              pop,
    output logic [bwt_pkg::LVL_W-1:0]         warning_level,
    output logic [bwt_pkg::ALARM_W-1:0]       alarm_event,
    output logic [bwt_pkg::SEV_W-1:0]         state_event,
    output logic                              capacity_alert,
    output logic [bwt_pkg::PCT_W-1:0]         capacity_out,

    // register write port
    input  logic                              cfg_write,
    input  logic [bwt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bwt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int QUEUE_DEPTH = 2;

    bwt_pkg::cfg_t    cfg_reg;
    bwt_pkg::item_t   front_item;
    bwt_pkg::item_t   mid_item;
    logic             mid_empty;
    logic             mid_pop;
    bwt_pkg::result_t back_result;
    logic             back_push;
    logic             res_full;
    bwt_pkg::result_t res_head;

    // threshold and notify registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_percent      <= bwt_pkg::RST_LOW_PERCENT;
            cfg_reg.critical_percent <= bwt_pkg::RST_CRITICAL_PERCENT;
            cfg_reg.action_percent   <= bwt_pkg::RST_ACTION_PERCENT;
            cfg_reg.low_seconds      <= bwt_pkg::RST_LOW_SECONDS;
            cfg_reg.critical_seconds <= bwt_pkg::RST_CRITICAL_SECONDS;
            cfg_reg.action_seconds   <= bwt_pkg::RST_ACTION_SECONDS;
            cfg_reg.use_time_policy  <= bwt_pkg::RST_USE_TIME_POLICY;
            cfg_reg.notify_mask      <= bwt_pkg::RST_NOTIFY_MASK;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bwt_pkg::CFG_LOW_PERCENT:
                    cfg_reg.low_percent <= cfg_data[bwt_pkg::PCT_W-1:0];
                bwt_pkg::CFG_CRITICAL_PERCENT:
                    cfg_reg.critical_percent <= cfg_data[bwt_pkg::PCT_W-1:0];
                bwt_pkg::CFG_ACTION_PERCENT:
                    cfg_reg.action_percent <= cfg_data[bwt_pkg::PCT_W-1:0];
                bwt_pkg::CFG_LOW_SECONDS:
                    cfg_reg.low_seconds <= cfg_data[bwt_pkg::SEC_W-1:0];
                bwt_pkg::CFG_CRITICAL_SECONDS:
                    cfg_reg.critical_seconds <= cfg_data[bwt_pkg::SEC_W-1:0];
                bwt_pkg::CFG_ACTION_SECONDS:
                    cfg_reg.action_seconds <= cfg_data[bwt_pkg::SEC_W-1:0];
                bwt_pkg::CFG_USE_TIME_POLICY:
                    cfg_reg.use_time_policy <= cfg_data[0];
                bwt_pkg::CFG_NOTIFY_MASK:
                    cfg_reg.notify_mask <= cfg_data[bwt_pkg::MASK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end: classify the report as it arrives
    bwt_front #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_front (
        .command          (command),
        .device_slot      (device_slot),
        .device_kind      (device_kind),
        .charge_state     (charge_state),
        .charge_percent   (charge_percent),
        .seconds_to_empty (seconds_to_empty),
        .capacity_percent (capacity_percent),
        .cfg              (cfg_reg),
        .item             (front_item)
    );

    // classified beats wait here for the back end
    bwt_fifo #(
        .WIDTH ($bits(bwt_pkg::item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_item),
        .full      (full),
        .pop       (mid_pop),
        .pop_data  (mid_item),
        .empty     (mid_empty)
    );

    // back end: slot table lookup, event detection, table update
    bwt_back #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item        (mid_item),
        .item_empty  (mid_empty),
        .item_pop    (mid_pop),
        .result      (back_result),
        .result_push (back_push),
        .result_full (res_full)
    );

    // finished results, oldest on the ports
    bwt_fifo #(
        .WIDTH ($bits(bwt_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (back_push),
        .push_data (back_result),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_head),
        .empty     (empty)
    );

    assign warning_level  = res_head.warning_level;
    assign alarm_event    = res_head.alarm_event;
    assign state_event    = res_head.state_event;
    assign capacity_alert = res_head.capacity_alert;
    assign capacity_out   = res_head.capacity_out;

endmodule

[test/tb.sv]
module tb;
    import bwt_pkg::*;

    // run shape
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTED = 10;

    // charge states and kinds that the package leaves unnamed
    localparam logic [STATE_W-1:0] CS_UNKNOWN  = 3'd0;
    localparam logic [STATE_W-1:0] CS_CHARGING = 3'd1;
    localparam logic [STATE_W-1:0] CS_OTHER    = 3'd4;
    localparam logic [STATE_W-1:0] CS_SPARE_LO = 3'd5;
    localparam logic [STATE_W-1:0] CS_SPARE_HI = 3'd7;
    localparam logic [KIND_W-1:0]  KIND_SPARE  = 3'd7;

    // largest legal register values
    localparam logic [PCT_W-1:0] PCT_TOP = 7'd100;
    localparam logic [SEC_W-1:0] SEC_TOP = '1;

    // one device report as it crosses the push side
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  slot;
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] state;
        logic [PCT_W-1:0]   pct;
        logic [SEC_W-1:0]   secs;
        logic [PCT_W-1:0]   cap;
    } report_t;

    // directed row: report plus an optional hand-written result
    typedef struct packed {
        report_t rpt;
        logic    typed;
        result_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // push side
    logic                push = 1'b0;
    logic                full;
    logic [CMD_W-1:0]    command = '0;
    logic [SLOT_W-1:0]   device_slot = '0;
    logic [KIND_W-1:0]   device_kind = '0;
    logic [STATE_W-1:0]  charge_state = '0;
    logic [PCT_W-1:0]    charge_percent = '0;
    logic [SEC_W-1:0]    seconds_to_empty = '0;
    logic [PCT_W-1:0]    capacity_percent = '0;

    // pop side
    logic                empty;
    logic                pop = 1'b0;
    logic [LVL_W-1:0]    warning_level;
    logic [ALARM_W-1:0]  alarm_event;
    logic [SEV_W-1:0]    state_event;
    logic                capacity_alert;
    logic [PCT_W-1:0]    capacity_out;

    // register port
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // hand-written result riding along with the current push beat
    logic    row_typed = 1'b0;
    result_t row_want = '0;

    // predictor state: registers and the per-slot table
    cfg_t               model_cfg;
    logic [LVL_W-1:0]   model_level [SLOT_COUNT];
    logic [STATE_W-1:0] model_state [SLOT_COUNT];

    // results still owed by the block, oldest first
    result_t pending_results [$];

    // stimulus bookkeeping: which slots hold an add, and their kind
    bit                slot_added [SLOT_COUNT];
    logic [KIND_W-1:0] slot_kind [SLOT_COUNT];

    int unsigned fault_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned send_calm = 0;
    int unsigned pop_calm = 0;
    int unsigned pop_hold = 0;

    battery_warning_tracker_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .command          (command),
        .device_slot      (device_slot),
        .device_kind      (device_kind),
        .charge_state     (charge_state),
        .charge_percent   (charge_percent),
        .seconds_to_empty (seconds_to_empty),
        .capacity_percent (capacity_percent),
        .empty            (empty),
        .pop              (pop),
        .warning_level    (warning_level),
        .alarm_event      (alarm_event),
        .state_event      (state_event),
        .capacity_alert   (capacity_alert),
        .capacity_out     (capacity_out),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #1 clk = ~clk;

    // idle length: mostly none, often a short gap, now and then a long pause
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // percent ladder shared by ups, pda, phone and batteries off the time policy or at zero time
    function automatic logic [LVL_W-1:0] pct_level(logic [PCT_W-1:0] pct);
        if (pct == '0)
            return LVL_NONE;
        if (pct <= model_cfg.action_percent)
            return LVL_ACTION;
        if (pct <= model_cfg.critical_percent)
            return LVL_CRITICAL;
        if (pct <= model_cfg.low_percent)
            return LVL_LOW;
        return LVL_NONE;
    endfunction

    // classify one report, form its result and update the slot table
    function automatic result_t predict_report(report_t r);
        result_t          res;
        logic [LVL_W-1:0] lvl;
        res = '0;
        lvl = LVL_NONE;
        case (r.kind)
            KIND_MOUSE, KIND_KEYBOARD:
            begin
                // fixed limits, critical checked first
                if (r.pct < PERIPH_CRIT_LIMIT)
                    lvl = LVL_CRITICAL;
                else if (r.pct < PERIPH_LOW_LIMIT)
                    lvl = LVL_LOW;
            end
            KIND_UPS, KIND_PDA, KIND_PHONE:
                lvl = pct_level(r.pct);
            KIND_BATTERY:
            begin
                // zero time falls back to percent
                if (!model_cfg.use_time_policy || r.secs == '0)
                    lvl = pct_level(r.pct);
                else if (r.secs <= model_cfg.action_seconds)
                    lvl = LVL_ACTION;
                else if (r.secs <= model_cfg.critical_seconds)
                    lvl = LVL_CRITICAL;
                else if (r.secs <= model_cfg.low_seconds)
                    lvl = LVL_LOW;
            end
            default:
                lvl = LVL_NONE;
        endcase
        if (lvl == LVL_NONE && r.state == CS_DISCHARGING)
            lvl = LVL_DISCHARGING;
        res.warning_level = lvl;

        if (r.command == CMD_ADD)
        begin
            model_level[r.slot] = lvl;
            model_state[r.slot] = r.state;
            if (r.kind == KIND_BATTERY && r.cap <= CAPACITY_LIMIT
                    && model_cfg.notify_mask[NOTIFY_CAPACITY])
            begin
                res.capacity_alert = 1'b1;
                res.capacity_out   = r.cap;
            end
        end
        else
        begin
            if (lvl != model_level[r.slot])
            begin
                case (lvl)
                    LVL_LOW:      res.alarm_event = ALARM_LOW;
                    LVL_CRITICAL: res.alarm_event = ALARM_CRITICAL;
                    LVL_ACTION:   res.alarm_event = ALARM_ACTION;
                    default:      res.alarm_event = ALARM_NONE;
                endcase
                model_level[r.slot] = lvl;
            end
            // state events keyed on the new state
            if (r.state != model_state[r.slot])
            begin
                if (r.state == CS_DISCHARGING && model_cfg.notify_mask[NOTIFY_DISCHARGE])
                    res.state_event = SEV_DISCHARGING;
                else if (r.state == CS_FULL && model_cfg.notify_mask[NOTIFY_FULL])
                    res.state_event = SEV_FULL;
                model_state[r.slot] = r.state;
            end
        end
        return res;
    endfunction

    function automatic void note_fault(string what, result_t want, result_t got);
        fault_count++;
        if (fault_count <= MAX_REPORTED)
            $display("%s: want lvl=%0d alarm=%0d sev=%0d capwarn=%0d cap=%0d",
                     what, want.warning_level, want.alarm_event, want.state_event,
                     want.capacity_alert, want.capacity_out,
                     "  got lvl=%0d alarm=%0d sev=%0d capwarn=%0d cap=%0d",
                     got.warning_level, got.alarm_event, got.state_event,
                     got.capacity_alert, got.capacity_out);
    endfunction

    function automatic script_row_t row(
        logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot, logic [KIND_W-1:0] kind,
        logic [STATE_W-1:0] st, logic [PCT_W-1:0] pct, logic [SEC_W-1:0] secs,
        logic [PCT_W-1:0] cap, logic typed, logic [LVL_W-1:0] lvl,
        logic [ALARM_W-1:0] alarm, logic [SEV_W-1:0] sev, logic lowcap,
        logic [PCT_W-1:0] capout);
        script_row_t s;
        s.rpt   = '{cmd, slot, kind, st, pct, secs, cap};
        s.typed = typed;
        s.want  = '{lvl, alarm, sev, lowcap, capout};
        return s;
    endfunction

    // random report: mostly updates to slots that hold an add, values
    // clustered on the thresholds so that level changes happen often
    function automatic report_t random_report();
        report_t     r;
        int unsigned pick;
        if ($urandom_range(0, 9) < 3)
            r.command = CMD_ADD;
        else
            r.command = CMD_UPDATE;

        if (r.command == CMD_ADD)
        begin
            r.slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
            r.kind = ($urandom_range(0, 4) < 2) ? KIND_BATTERY : KIND_W'($urandom_range(0, 7));
        end
        else
        begin
            // the slot table is undefined until an add, so only added slots
            do
                r.slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
            while (!slot_added[r.slot]);
            r.kind = ($urandom_range(0, 4) != 0) ? slot_kind[r.slot]
                                                  : KIND_W'($urandom_range(0, 7));
        end

        if ($urandom_range(0, 9) < 3)
            r.state = STATE_W'($urandom_range(0, 7));
        else
            case ($urandom_range(0, 2))
                0:       r.state = CS_CHARGING;
                1:       r.state = CS_DISCHARGING;
                default: r.state = CS_FULL;
            endcase

        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.pct = PCT_W'($urandom_range(0, 30));
        else if (pick < 6)
        begin
            case ($urandom_range(0, 2))
                0:       r.pct = model_cfg.low_percent;
                1:       r.pct = model_cfg.critical_percent;
                default: r.pct = model_cfg.action_percent;
            endcase
            r.pct = r.pct + PCT_W'($urandom_range(0, 2)) - PCT_W'(1);
        end
        else if (pick < 7)
            r.pct = ($urandom_range(0, 1) ? PERIPH_CRIT_LIMIT : PERIPH_LOW_LIMIT)
                    - PCT_W'($urandom_range(0, 1));
        else
            r.pct = PCT_W'($urandom_range(0, 127));

        pick = $urandom_range(0, 9);
        if (pick < 2)
            r.secs = '0;
        else if (pick < 5)
            r.secs = SEC_W'($urandom_range(0, 2000));
        else if (pick < 7)
        begin
            case ($urandom_range(0, 2))
                0:       r.secs = model_cfg.low_seconds;
                1:       r.secs = model_cfg.critical_seconds;
                default: r.secs = model_cfg.action_seconds;
            endcase
            r.secs = r.secs + SEC_W'($urandom_range(0, 2)) - SEC_W'(1);
        end
        else
            r.secs = SEC_W'($urandom());

        r.cap = $urandom_range(0, 1) ? PCT_W'($urandom_range(0, 127))
                                     : PCT_W'($urandom_range(45, 55));
        return r;
    endfunction

    // present one report and hold it until the push beat is taken
    task automatic send_report(report_t r, logic typed, result_t want);
        int unsigned gap;
        command          <= r.command;
        device_slot      <= r.slot;
        device_kind      <= r.kind;
        charge_state     <= r.state;
        charge_percent   <= r.pct;
        seconds_to_empty <= r.secs;
        capacity_percent <= r.cap;
        row_typed        <= typed;
        row_want         <= want;
        push             <= 1'b1;
        if (r.command == CMD_ADD)
        begin
            slot_added[r.slot] = 1'b1;
            slot_kind[r.slot]  = r.kind;
        end
        do
            @(posedge clk);
        while (full);
        // calm stretches keep push high back to back
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            send_calm = $urandom_range(20, 80);
            gap = 0;
        end
        else
            gap = idle_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // stop pushing and let every owed result come out
    task automatic drain_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // pop side: random holds, with calm stretches where pop stays high
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (pop_calm > 0)
                pop_calm--;
            else if ($urandom_range(0, 39) == 0)
                pop_calm = $urandom_range(20, 80);
            else
                pop_hold = idle_len();
        end
    end

    // monitor: checks result beats, predicts push beats, tracks register
    // writes and watches for a hung block
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        report_t seen;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = '{warning_level, alarm_event, state_event, capacity_alert,
                        capacity_out};
                if (pending_results.size() == 0)
                    note_fault("result beat with nothing owed", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_fault("result mismatch", want, got);
                end
            end

            if (push && !full)
            begin
                seen = '{command, device_slot, device_kind, charge_state,
                         charge_percent, seconds_to_empty, capacity_percent};
                want = predict_report(seen);
                // hand-written rows override the predictor's answer
                pending_results.push_back(row_typed ? row_want : want);
            end

            if (cfg_write)
                case (cfg_index)
                    CFG_LOW_PERCENT:      model_cfg.low_percent      = cfg_data[PCT_W-1:0];
                    CFG_CRITICAL_PERCENT: model_cfg.critical_percent = cfg_data[PCT_W-1:0];
                    CFG_ACTION_PERCENT:   model_cfg.action_percent   = cfg_data[PCT_W-1:0];
                    CFG_LOW_SECONDS:      model_cfg.low_seconds      = cfg_data[SEC_W-1:0];
                    CFG_CRITICAL_SECONDS: model_cfg.critical_seconds = cfg_data[SEC_W-1:0];
                    CFG_ACTION_SECONDS:   model_cfg.action_seconds   = cfg_data[SEC_W-1:0];
                    CFG_USE_TIME_POLICY:  model_cfg.use_time_policy  = cfg_data[0];
                    default:              model_cfg.notify_mask      = cfg_data[MASK_W-1:0];
                endcase

            if ((push && !full) || (pop && !empty) || cfg_write)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        script_row_t          rows [$];
        logic [PCT_W-1:0]     lo_p;
        logic [PCT_W-1:0]     crit_p;
        logic [PCT_W-1:0]     act_p;
        logic [SEC_W-1:0]     lo_s;
        logic [SEC_W-1:0]     crit_s;
        logic [SEC_W-1:0]     act_s;
        logic                 policy;
        logic [MASK_W-1:0]    mask;

        model_cfg = '{RST_LOW_PERCENT, RST_CRITICAL_PERCENT, RST_ACTION_PERCENT,
                      RST_LOW_SECONDS, RST_CRITICAL_SECONDS, RST_ACTION_SECONDS,
                      RST_USE_TIME_POLICY, RST_NOTIFY_MASK};

        // directed beats under reset defaults; typed rows carry their result
        // battery walking down the time ladder on slot 0
        rows.push_back(row(CMD_ADD, 4'd0, KIND_BATTERY, CS_DISCHARGING, 7'd50, 24'd5000, 7'd100,
                           1'b1, LVL_DISCHARGING, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd0, KIND_BATTERY, CS_DISCHARGING, 7'd50, 24'd1200,
                           7'd100, 1'b1, LVL_LOW, ALARM_LOW, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd0, KIND_BATTERY, CS_DISCHARGING, 7'd50, 24'd300,
                           7'd100, 1'b1, LVL_CRITICAL, ALARM_CRITICAL, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd0, KIND_BATTERY, CS_DISCHARGING, 7'd50, 24'd120,
                           7'd100, 1'b1, LVL_ACTION, ALARM_ACTION, SEV_NONE, 1'b0, 7'd0));
        // same level again: no alarm
        rows.push_back(row(CMD_UPDATE, 4'd0, KIND_BATTERY, CS_DISCHARGING, 7'd50, 24'd1,
                           7'd100, 1'b1, LVL_ACTION, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        // zero time falls back to percent
        rows.push_back(row(CMD_UPDATE, 4'd0, KIND_BATTERY, CS_FULL, 7'd100, 24'd0, 7'd100,
                           1'b1, LVL_NONE, ALARM_NONE, SEV_FULL, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd0, KIND_BATTERY, CS_DISCHARGING, 7'd2, 24'd0,
                           7'd100, 1'b1, LVL_ACTION, ALARM_ACTION, SEV_DISCHARGING, 1'b0, 7'd0));
        // low capacity on add, at the limit and at zero
        rows.push_back(row(CMD_ADD, 4'd15, KIND_BATTERY, CS_CHARGING, 7'd0, SEC_TOP, 7'd50,
                           1'b1, LVL_NONE, ALARM_NONE, SEV_NONE, 1'b1, 7'd50));
        // percent beyond 100 compared as given
        rows.push_back(row(CMD_ADD, 4'd1, KIND_BATTERY, CS_UNKNOWN, 7'd127, 24'd0, 7'd0,
                           1'b1, LVL_NONE, ALARM_NONE, SEV_NONE, 1'b1, 7'd0));
        // ups at zero percent: no threshold warning
        rows.push_back(row(CMD_ADD, 4'd2, KIND_UPS, CS_DISCHARGING, 7'd0, 24'd0, 7'd0,
                           1'b1, LVL_DISCHARGING, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd2, KIND_UPS, CS_DISCHARGING, 7'd1, 24'd0, 7'd0,
                           1'b1, LVL_ACTION, ALARM_ACTION, SEV_NONE, 1'b0, 7'd0));
        // mouse and keyboard fixed limits on both sides of each edge
        rows.push_back(row(CMD_ADD, 4'd3, KIND_MOUSE, CS_CHARGING, 7'd12, 24'd0, 7'd0,
                           1'b1, LVL_CRITICAL, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd3, KIND_MOUSE, CS_CHARGING, 7'd13, 24'd0, 7'd0,
                           1'b1, LVL_LOW, ALARM_LOW, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd3, KIND_MOUSE, CS_DISCHARGING, 7'd26, 24'd0, 7'd0,
                           1'b1, LVL_DISCHARGING, ALARM_NONE, SEV_DISCHARGING, 1'b0, 7'd0));
        rows.push_back(row(CMD_ADD, 4'd4, KIND_KEYBOARD, CS_OTHER, 7'd25, 24'd0, 7'd0,
                           1'b1, LVL_LOW, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        // pda and phone, with unlisted charge states
        rows.push_back(row(CMD_ADD, 4'd5, KIND_PDA, CS_SPARE_HI, 7'd3, 24'd0, 7'd0,
                           1'b0, '0, '0, '0, 1'b0, '0));
        rows.push_back(row(CMD_ADD, 4'd6, KIND_PHONE, CS_DISCHARGING, 7'd10, 24'd0, 7'd0,
                           1'b0, '0, '0, '0, 1'b0, '0));
        rows.push_back(row(CMD_UPDATE, 4'd6, KIND_PHONE, CS_SPARE_LO, 7'd11, 24'd0, 7'd0,
                           1'b0, '0, '0, '0, 1'b0, '0));
        // other kind and the unlisted kind: no threshold warning
        rows.push_back(row(CMD_ADD, 4'd7, KIND_OTHER, CS_DISCHARGING, 7'd1, 24'd0, 7'd0,
                           1'b1, LVL_DISCHARGING, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        rows.push_back(row(CMD_ADD, 4'd8, KIND_SPARE, CS_DISCHARGING, 7'd1, 24'd0, 7'd10,
                           1'b1, LVL_DISCHARGING, ALARM_NONE, SEV_NONE, 1'b0, 7'd0));
        // update never reports low capacity
        rows.push_back(row(CMD_UPDATE, 4'd1, KIND_BATTERY, CS_FULL, 7'd50, 24'd1201, 7'd10,
                           1'b1, LVL_NONE, ALARM_NONE, SEV_FULL, 1'b0, 7'd0));
        rows.push_back(row(CMD_UPDATE, 4'd15, KIND_BATTERY, CS_DISCHARGING, 7'd100, 24'd121,
                           7'd127, 1'b0, '0, '0, '0, 1'b0, '0));

        // single reset at the start of the run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_report(rows[i].rpt, rows[i].typed, rows[i].want);
        drain_results();

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    // everything at its floor, events masked off
                    lo_p = '0; crit_p = '0; act_p = '0;
                    lo_s = '0; crit_s = '0; act_s = '0;
                    policy = 1'b1; mask = '0;
                end
                1:
                begin
                    // everything at its ceiling
                    lo_p = PCT_TOP; crit_p = PCT_TOP; act_p = PCT_TOP;
                    lo_s = SEC_TOP; crit_s = SEC_TOP; act_s = SEC_TOP;
                    policy = 1'b1; mask = '1;
                end
                2:
                begin
                    // defaults with batteries on the percent ladder
                    lo_p = RST_LOW_PERCENT; crit_p = RST_CRITICAL_PERCENT;
                    act_p = RST_ACTION_PERCENT;
                    lo_s = RST_LOW_SECONDS; crit_s = RST_CRITICAL_SECONDS;
                    act_s = RST_ACTION_SECONDS;
                    policy = 1'b0; mask = MASK_W'($urandom_range(0, 7));
                end
                default:
                begin
                    lo_p   = PCT_W'($urandom_range(0, 100));
                    crit_p = PCT_W'($urandom_range(0, 100));
                    act_p  = PCT_W'($urandom_range(0, 100));
                    // half the time a proper ladder, otherwise any order
                    if ($urandom_range(0, 1))
                    begin
                        act_p  = PCT_W'($urandom_range(0, 10));
                        crit_p = act_p + PCT_W'($urandom_range(0, 10));
                        lo_p   = crit_p + PCT_W'($urandom_range(0, 30));
                    end
                    lo_s   = $urandom_range(0, 1) ? SEC_W'($urandom_range(0, 3000))
                                                  : SEC_W'($urandom());
                    crit_s = $urandom_range(0, 1) ? SEC_W'($urandom_range(0, 1000))
                                                  : SEC_W'($urandom());
                    act_s  = $urandom_range(0, 1) ? SEC_W'($urandom_range(0, 400))
                                                  : SEC_W'($urandom());
                    policy = 1'($urandom_range(0, 1));
                    mask   = MASK_W'($urandom_range(0, 7));
                end
            endcase

            // block is idle here: every owed result has come out
            write_reg(CFG_LOW_PERCENT, CFG_DATA_W'(lo_p));
            write_reg(CFG_CRITICAL_PERCENT, CFG_DATA_W'(crit_p));
            write_reg(CFG_ACTION_PERCENT, CFG_DATA_W'(act_p));
            write_reg(CFG_LOW_SECONDS, CFG_DATA_W'(lo_s));
            write_reg(CFG_CRITICAL_SECONDS, CFG_DATA_W'(crit_s));
            write_reg(CFG_ACTION_SECONDS, CFG_DATA_W'(act_s));
            write_reg(CFG_USE_TIME_POLICY, CFG_DATA_W'(policy));
            write_reg(CFG_NOTIFY_MASK, CFG_DATA_W'(mask));
            cfg_write <= 1'b0;

            repeat (PHASE_ITEMS)
                send_report(random_report(), 1'b0, '0);
            drain_results();
        end

        // wait TAIL_CYCLES more to catch stray result beats
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/bwt_pkg.sv
rtl/bwt_ram.sv
rtl/bwt_fifo.sv
rtl/bwt_front.sv
rtl/bwt_back.sv
rtl/battery_warning_tracker_core.sv
test/tb.sv
